@@ rtl/core/fcol_pkg.sv @@
// Shared types and constants for the fixed capacity ordered list.
package fcol_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int CMD_W        = 3;
  localparam int VALUE_W      = 32;
  localparam int POS_W        = 4;
  localparam int COUNT_W      = 5;
  localparam int INDEX_W      = 4;
  localparam int QUEUE_DEPTH  = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FRONT  = 3'd0,
    CMD_INS_BACK   = 3'd1,
    CMD_INS_SORTED = 3'd2,
    CMD_RM_FRONT   = 3'd3,
    CMD_RM_BACK    = 3'd4,
    CMD_RM_VALUE   = 3'd5,
    CMD_FIND       = 3'd6,
    CMD_READ_POS   = 3'd7
  } cmd_t;

  // Guard class: inserts need room, everything else needs a nonempty list.
  typedef enum logic [1:0] {
    CLS_INSERT,
    CLS_REMOVE,
    CLS_LOOKUP
  } cls_t;

  typedef struct packed {
    cmd_t                      cmd;
    cls_t                      cls;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;
  } item_t;

endpackage

@@ rtl/core/fcol_req_if.sv @@
// Command channel: valid/ready handshake with command payload.
interface fcol_req_if;
  logic                                valid;
  logic                                ready;
  logic [fcol_pkg::CMD_W-1:0]          cmd;
  logic signed [fcol_pkg::VALUE_W-1:0] value;
  logic [fcol_pkg::POS_W-1:0]          position;

  modport source (output valid, cmd, value, position, input ready);
  modport sink (input valid, cmd, value, position, output ready);
endinterface

@@ rtl/core/fcol_rsp_if.sv @@
// Result channel: valid/ready handshake with result payload.
interface fcol_rsp_if;
  logic                                valid;
  logic                                ready;
  logic                                ok;
  logic [fcol_pkg::COUNT_W-1:0]        count;
  logic signed [fcol_pkg::VALUE_W-1:0] read_value;
  logic [fcol_pkg::INDEX_W-1:0]        found_index;

  modport source (output valid, ok, count, read_value, found_index, input ready);
  modport sink (input valid, ok, count, read_value, found_index, output ready);
endinterface

@@ rtl/core/fcol_front.sv @@
// Front end: takes command beats and classifies them into queue items.
module fcol_front (
  fcol_req_if.sink         req,
  input  logic             room,
  output logic             push,
  output fcol_pkg::item_t  item
);

  fcol_pkg::cmd_t cmd;

  assign cmd       = fcol_pkg::cmd_t'(req.cmd);
  assign req.ready = room;
  assign push      = req.valid && room;

  always_comb begin
    item.cmd      = cmd;
    item.value    = req.value;
    item.position = req.position;
    case (cmd) inside
      fcol_pkg::CMD_INS_FRONT, fcol_pkg::CMD_INS_BACK, fcol_pkg::CMD_INS_SORTED:
        item.cls = fcol_pkg::CLS_INSERT;
      fcol_pkg::CMD_RM_FRONT, fcol_pkg::CMD_RM_BACK, fcol_pkg::CMD_RM_VALUE:
        item.cls = fcol_pkg::CLS_REMOVE;
      default:
        item.cls = fcol_pkg::CLS_LOOKUP;
    endcase
  end

endmodule

@@ rtl/core/fcol_queue.sv @@
// Short FIFO between the front end and the list back end.
module fcol_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  fcol_pkg::item_t push_item,
  output logic            room,
  output logic            avail,
  input  logic            pop,
  output fcol_pkg::item_t head
);

  localparam int PTR_W  = (fcol_pkg::QUEUE_DEPTH > 1) ? $clog2(fcol_pkg::QUEUE_DEPTH) : 1;
  localparam int USED_W = $clog2(fcol_pkg::QUEUE_DEPTH + 1);

  fcol_pkg::item_t   slots [fcol_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [USED_W-1:0] used;

  assign room  = used != USED_W'(fcol_pkg::QUEUE_DEPTH);
  assign avail = used != '0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      used   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(fcol_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(fcol_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        used <= used + 1'b1;
      end else if (pop && !push) begin
        used <= used - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

@@ rtl/core/fcol_back.sv @@
// Back end: list cells that compare and shift in parallel, plus result register.
module fcol_back #(
  parameter int CAPACITY = fcol_pkg::CAPACITY_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            avail,
  input  fcol_pkg::item_t head,
  output logic            pop,
  fcol_rsp_if.source      rsp
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > fcol_pkg::POS_W) ? CNT_W : fcol_pkg::POS_W;

  logic signed [fcol_pkg::VALUE_W-1:0] cells      [CAPACITY];
  logic signed [fcol_pkg::VALUE_W-1:0] cells_next [CAPACITY];
  logic signed [fcol_pkg::VALUE_W-1:0] up         [CAPACITY];
  logic signed [fcol_pkg::VALUE_W-1:0] dn         [CAPACITY];
  logic [CNT_W-1:0]                    cnt;
  logic [CNT_W-1:0]                    cnt_next;
  logic [CAPACITY-1:0]                 eq;
  logic [CAPACITY-1:0]                 lt;
  logic [CNT_W-1:0]                    hit_at;
  logic [CNT_W-1:0]                    ord_at;
  logic [CNT_W-1:0]                    edit_at;
  logic                                hit;
  logic                                guard;
  logic                                ok;
  logic                                do_ins;
  logic                                do_rm;
  logic signed [fcol_pkg::VALUE_W-1:0] rd_sel;
  logic signed [fcol_pkg::VALUE_W-1:0] rd;
  logic [CNT_W-1:0]                    fidx;
  logic                                out_valid;

  assign pop       = avail && (!out_valid || rsp.ready);
  assign rsp.valid = out_valid;

  // Per-cell compares and first-hit search.
  always_comb begin
    hit_at = '0;
    ord_at = cnt;
    rd_sel = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      eq[k] = (CNT_W'(k) < cnt) && (cells[k] == head.value);
      lt[k] = (CNT_W'(k) < cnt) && (cells[k] < head.value);
      if (CMP_W'(k) == CMP_W'(head.position)) begin
        rd_sel = cells[k];
      end
    end
    for (int k = CAPACITY - 1; k >= 0; k--) begin
      if (eq[k]) begin
        hit_at = CNT_W'(k);
      end
      if (!lt[k]) begin
        ord_at = CNT_W'(k);
      end
    end
    hit = |eq;
  end

  always_comb begin
    guard    = (head.cls == fcol_pkg::CLS_INSERT) ? (cnt != CNT_W'(CAPACITY)) : (cnt != '0);
    ok       = 1'b0;
    do_ins   = 1'b0;
    do_rm    = 1'b0;
    edit_at  = '0;
    rd       = '0;
    fidx     = '0;
    case (head.cmd)
      fcol_pkg::CMD_INS_FRONT: begin
        do_ins = guard;
      end
      fcol_pkg::CMD_INS_BACK: begin
        do_ins  = guard;
        edit_at = cnt;
      end
      fcol_pkg::CMD_INS_SORTED: begin
        do_ins  = guard;
        edit_at = ord_at;
      end
      fcol_pkg::CMD_RM_FRONT: begin
        do_rm = guard;
      end
      fcol_pkg::CMD_RM_BACK: begin
        do_rm   = guard;
        edit_at = cnt - 1'b1;
      end
      fcol_pkg::CMD_RM_VALUE: begin
        do_rm   = guard && hit;
        edit_at = hit_at;
      end
      fcol_pkg::CMD_FIND: begin
        ok = guard && hit;
        if (ok) begin
          fidx = hit_at;
        end
      end
      fcol_pkg::CMD_READ_POS: begin
        ok = CMP_W'(head.position) < CMP_W'(cnt);
        if (ok) begin
          rd = rd_sel;
        end
      end
      default: ;
    endcase
    if (do_ins || do_rm) begin
      ok = 1'b1;
    end
    cnt_next = do_ins ? cnt + 1'b1 : (do_rm ? cnt - 1'b1 : cnt);
  end

  // Shift paths: open a slot at edit_at, or close the slot at edit_at.
  always_comb begin
    up[0]          = head.value;
    dn[CAPACITY-1] = cells[CAPACITY-1];
    for (int k = 1; k < CAPACITY; k++) begin
      up[k] = cells[k-1];
    end
    for (int k = 0; k < CAPACITY - 1; k++) begin
      dn[k] = cells[k+1];
    end
    for (int k = 0; k < CAPACITY; k++) begin
      if (CNT_W'(k) < edit_at) begin
        cells_next[k] = cells[k];
      end else if (do_ins) begin
        cells_next[k] = (CNT_W'(k) == edit_at) ? head.value : up[k];
      end else begin
        cells_next[k] = dn[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        cnt       <= cnt_next;
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rsp.ok          <= ok;
      rsp.count       <= fcol_pkg::COUNT_W'(cnt_next);
      rsp.read_value  <= rd;
      rsp.found_index <= fcol_pkg::INDEX_W'(fidx);
      if (do_ins || do_rm) begin
        for (int k = 0; k < CAPACITY; k++) begin
          cells[k] <= cells_next[k];
        end
      end
    end
  end

endmodule

@@ rtl/core/fixed_capacity_ordered_list.sv @@
// Top level of the fixed capacity ordered list: front end, queue and list back end.
//
//   channel | role   | payload
//   --------+--------+------------------------------------------
//   req     | sink   | cmd, value, position
//   rsp     | source | ok, count, read_value, found_index
//
// One command per cycle sustained while rsp is ready; the limit is the combinational
// compare and shift across all list cells. Results leave through a result register.
// Reset clears the fill count, queue and result valid; entry contents stay unknown.
// A stalled rsp fills the queue, then req.ready drops until rsp drains.
module fixed_capacity_ordered_list #(
  parameter int CAPACITY = fcol_pkg::CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst,
  fcol_req_if.sink   req,
  fcol_rsp_if.source rsp
);

  fcol_pkg::item_t push_item;
  fcol_pkg::item_t head;
  logic            push;
  logic            room;
  logic            avail;
  logic            pop;

  fcol_front u_front (
    .req  (req),
    .room (room),
    .push (push),
    .item (push_item)
  );

  fcol_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .room      (room),
    .avail     (avail),
    .pop       (pop),
    .head      (head)
  );

  fcol_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk   (clk),
    .rst   (rst),
    .avail (avail),
    .head  (head),
    .pop   (pop),
    .rsp   (rsp)
  );

endmodule

@@ bench/fixed_capacity_ordered_list_tb.sv @@
// Testbench for the fixed capacity ordered list: directed, stall and random command streams.
module fixed_capacity_ordered_list_tb;
  import fcol_pkg::*;

  localparam int LIST_DEPTH     = CAPACITY_DEF;
  localparam int HOLD_CYCLES    = 60;
  localparam int DRAIN_LIMIT    = 10000;
  localparam int TAIL_CYCLES    = 8;
  localparam int TIMEOUT_CYCLES = 200000;
  localparam int CLK_PERIOD     = 20;
  localparam int RESET_CYCLES   = 12;
  localparam int ITEMS_PER_PASS = 635;
  localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

  typedef struct packed {
    logic                      ok;
    logic [COUNT_W-1:0]        count;
    logic signed [VALUE_W-1:0] read_value;
    logic [INDEX_W-1:0]        found_index;
  } list_result_t;

  logic clk;
  logic rst;

  fcol_req_if req_ch ();
  fcol_rsp_if rsp_ch ();

  fixed_capacity_ordered_list dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Shadow copy of the list, updated when a command beat is accepted.
  logic signed [VALUE_W-1:0] list_store [LIST_DEPTH];
  int                        list_len = 0;
  list_result_t              pending_results [$];
  int                        fail_count = 0;
  int                        send_idle_pct = 0;
  int                        rcv_idle_pct = 0;
  logic                      hold_rsp = 1'b0;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic int find_slot(logic signed [VALUE_W-1:0] v);
    int i;
    i = 0;
    while (i < list_len && list_store[i] != v) i++;
    return i;
  endfunction

  function automatic list_result_t apply_list_cmd(cmd_t op, logic signed [VALUE_W-1:0] v,
                                                  logic [POS_W-1:0] p);
    list_result_t res;
    int at;
    int k;
    res = '0;
    at = 0;
    case (op)
      CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_SORTED: begin
        if (list_len < LIST_DEPTH) begin
          if (op == CMD_INS_BACK) at = list_len;
          // Equal values go ahead of existing ones.
          else if (op == CMD_INS_SORTED)
            while (at < list_len && list_store[at] < v) at++;
          for (k = list_len; k > at; k--) list_store[k] = list_store[k-1];
          list_store[at] = v;
          list_len++;
          res.ok = 1'b1;
        end
      end
      CMD_RM_FRONT, CMD_RM_BACK, CMD_RM_VALUE: begin
        if (op == CMD_RM_BACK) at = list_len - 1;
        else if (op == CMD_RM_VALUE) at = find_slot(v);
        if (list_len > 0 && at < list_len) begin
          for (k = at; k + 1 < list_len; k++) list_store[k] = list_store[k+1];
          list_len--;
          res.ok = 1'b1;
        end
      end
      CMD_FIND: begin
        at = find_slot(v);
        if (at < list_len) begin
          res.found_index = INDEX_W'(at);
          res.ok = 1'b1;
        end
      end
      default: begin
        if (p < list_len) begin
          res.read_value = list_store[p];
          res.ok = 1'b1;
        end
      end
    endcase
    res.count = COUNT_W'(list_len);
    return res;
  endfunction

  // Favor values already stored so removes and finds hit often.
  function automatic logic signed [VALUE_W-1:0] pick_operand();
    int roll;
    roll = $urandom_range(99);
    if (list_len > 0 && roll < 40) return list_store[$urandom_range(list_len - 1)];
    if (roll < 70) return $urandom_range(16) - 8;
    if (roll < 76) return $urandom_range(1) ? VALUE_MIN : VALUE_MAX;
    return $urandom;
  endfunction

  task automatic send_cmd(cmd_t op, logic signed [VALUE_W-1:0] v, logic [POS_W-1:0] p);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.cmd      <= op;
    req_ch.value    <= v;
    req_ch.position <= p;
    do @(posedge clk); while (!req_ch.ready);
    pending_results.push_back(apply_list_cmd(op, v, p));
  endtask

  // Receiver: random stalls, or one long hold-off on request.
  initial begin
    logic hold_taken;
    hold_taken = 1'b0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_rsp && !hold_taken) begin
        hold_taken   = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    list_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no command pending");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (rsp_ch.ok !== want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, rsp_ch.ok);
          fail_count++;
        end
        if (rsp_ch.count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, rsp_ch.count);
          fail_count++;
        end
        if (rsp_ch.read_value !== want.read_value) begin
          $error("read_value: expected %0d, got %0d", want.read_value, rsp_ch.read_value);
          fail_count++;
        end
        if (rsp_ch.found_index !== want.found_index) begin
          $error("found_index: expected %0d, got %0d", want.found_index, rsp_ch.found_index);
          fail_count++;
        end
      end
    end
  end

  task automatic test_empty_and_extremes();
    send_cmd(CMD_RM_FRONT, 0, 0);
    send_cmd(CMD_RM_BACK, 0, 0);
    send_cmd(CMD_RM_VALUE, 5, 0);
    send_cmd(CMD_FIND, 5, 0);
    send_cmd(CMD_READ_POS, 0, 0);
    send_cmd(CMD_INS_BACK, VALUE_MIN, 0);
    send_cmd(CMD_INS_FRONT, VALUE_MAX, 0);
    send_cmd(CMD_INS_SORTED, 0, 0);
    send_cmd(CMD_INS_SORTED, 0, 0);
    send_cmd(CMD_INS_SORTED, -1, 0);
    send_cmd(CMD_FIND, 0, 0);
    send_cmd(CMD_READ_POS, 0, 4'hF);
    send_cmd(CMD_READ_POS, 0, 0);
    send_cmd(CMD_RM_VALUE, 32'h1234_5678, 0);
    send_cmd(CMD_RM_VALUE, 0, 0);
    send_cmd(CMD_FIND, VALUE_MIN, 0);
    send_cmd(CMD_RM_FRONT, 0, 0);
    send_cmd(CMD_RM_BACK, 0, 0);
  endtask

  // Hold the result side while filling the list so the input stalls.
  task automatic test_full_under_stall();
    hold_rsp <= 1'b1;
    while (list_len < LIST_DEPTH)
      send_cmd(cmd_t'($urandom_range(int'(CMD_INS_SORTED), int'(CMD_INS_FRONT))),
               pick_operand(), POS_W'($urandom_range(LIST_DEPTH - 1)));
    send_cmd(CMD_INS_FRONT, 1, 0);
    send_cmd(CMD_INS_BACK, 2, 0);
    send_cmd(CMD_INS_SORTED, 3, 0);
    send_cmd(CMD_READ_POS, 0, POS_W'(LIST_DEPTH - 1));
    send_cmd(CMD_FIND, list_store[LIST_DEPTH-1], 0);
  endtask

  task automatic test_random_traffic(int n_items);
    int   ins_pct;
    int   n;
    cmd_t op;
    ins_pct = 50;
    for (n = 0; n < n_items; n++) begin
      // Shift the insert/remove balance so the fill level sweeps empty to full.
      if (n % 64 == 0) ins_pct = 25 * $urandom_range(3, 1);
      if ($urandom_range(99) < 30)
        op = $urandom_range(1) ? CMD_FIND : CMD_READ_POS;
      else if ($urandom_range(99) < ins_pct)
        op = cmd_t'($urandom_range(int'(CMD_INS_SORTED), int'(CMD_INS_FRONT)));
      else
        op = cmd_t'($urandom_range(int'(CMD_RM_VALUE), int'(CMD_RM_FRONT)));
      send_cmd(op, pick_operand(), POS_W'($urandom_range(LIST_DEPTH - 1)));
    end
  endtask

  initial begin
    int waited;
    req_ch.valid    <= 1'b0;
    req_ch.cmd      <= CMD_INS_FRONT;
    req_ch.value    <= '0;
    req_ch.position <= '0;
    rst             <= 1'b1;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 15;
    rcv_idle_pct  = 49;
    test_empty_and_extremes();
    test_random_traffic(ITEMS_PER_PASS);

    send_idle_pct = 49;
    rcv_idle_pct  = 15;
    test_random_traffic(ITEMS_PER_PASS);

    send_idle_pct = 0;
    rcv_idle_pct  = 0;
    test_full_under_stall();
    test_random_traffic(ITEMS_PER_PASS);
    req_ch.valid <= 1'b0;

    waited = 0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      fail_count++;
    end

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
